// ===== src/amam_pkg.sv =====
package amam_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int AXES         = 3;
    localparam int MAG_W        = 16;
    localparam int FILL_LEVEL_W = 4;
    localparam int SUMSQ_W      = 32;
    localparam int ROOT_STEPS   = SUMSQ_W / 2;

    localparam logic [SUMSQ_W-1:0] ROOT_BIT0 = SUMSQ_W'(1) << (SUMSQ_W - 2);

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_SUM_TAIL,
        ST_DIV_INIT,
        ST_DIV,
        ST_SQ,
        ST_SQ_TAIL,
        ST_ROOT_INIT,
        ST_ROOT,
        ST_DONE
    } amam_state_t;

    typedef struct packed {
        logic       load;
        logic       rd_issue;
        logic       div_init;
        logic       div_step;
        logic       sq_issue;
        logic [1:0] sq_sel;
        logic       root_init;
        logic       root_step;
        logic       out_load;
    } amam_cmd_t;

    typedef struct packed {
        logic rd_last;
        logic out_busy;
    } amam_sts_t;

endpackage

// ===== src/amam_ram.sv =====
module amam_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/amam_ctrl.sv =====
module amam_ctrl import amam_pkg::*; #(
    parameter int WINDOW = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  amam_sts_t sts,
    output amam_cmd_t cmd
);

    localparam int FW        = $clog2(WINDOW + 1);
    localparam int DIV_STEPS = SAMPLE_W + FW - 1;
    localparam int MAXS      = (DIV_STEPS > ROOT_STEPS) ? DIV_STEPS : ROOT_STEPS;
    localparam int CW        = $clog2(MAXS);

    amam_state_t   state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.rd_issue = 1'b1;
                if (sts.rd_last)
                begin
                    state_next = ST_SUM_TAIL;
                end
            end
            ST_SUM_TAIL:
            begin
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CW'(1);
                if (cnt_reg == CW'(DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                cmd.sq_issue = 1'b1;
                cmd.sq_sel   = cnt_reg[1:0];
                cnt_next     = cnt_reg + CW'(1);
                if (cnt_reg == CW'(AXES - 1))
                begin
                    state_next = ST_SQ_TAIL;
                end
            end
            ST_SQ_TAIL:
            begin
                state_next = ST_ROOT_INIT;
            end
            ST_ROOT_INIT:
            begin
                cmd.root_init = 1'b1;
                cnt_next      = '0;
                state_next    = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + CW'(1);
                if (cnt_reg == CW'(ROOT_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/amam_dp.sv =====
module amam_dp import amam_pkg::*; #(
    parameter int WINDOW = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic signed [SAMPLE_W-1:0]     accel_x,
    input  logic signed [SAMPLE_W-1:0]     accel_y,
    input  logic signed [SAMPLE_W-1:0]     accel_z,
    input  amam_cmd_t                      cmd,
    output amam_sts_t                      sts,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_W-1:0]     avg_x,
    output logic signed [SAMPLE_W-1:0]     avg_y,
    output logic signed [SAMPLE_W-1:0]     avg_z,
    output logic [MAG_W-1:0]               magnitude,
    output logic [FILL_LEVEL_W-1:0]        fill_level
);

    localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FW    = $clog2(WINDOW + 1);
    localparam int SW    = SAMPLE_W + FW;
    localparam int MW    = SW - 1;
    localparam int RW    = FW + 1;
    localparam int MEM_W = AXES * SAMPLE_W;

    logic [AW-1:0] slot_reg, slot_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic          rd_valid_reg, rd_valid_next;
    logic          prod_valid_reg, prod_valid_next;
    logic          out_valid_reg, out_valid_next;

    logic signed [SW-1:0]       acc_reg [AXES];
    logic signed [SW-1:0]       acc_next [AXES];
    logic                       neg_reg [AXES];
    logic                       neg_next [AXES];
    logic [MW-1:0]              dvd_reg [AXES];
    logic [MW-1:0]              dvd_next [AXES];
    logic [FW-1:0]              rem_reg [AXES];
    logic [FW-1:0]              rem_next [AXES];
    logic [SUMSQ_W-1:0]         prod_reg, prod_next;
    logic [SUMSQ_W-1:0]         sumsq_reg, sumsq_next;
    logic [SUMSQ_W-1:0]         rv_reg, rv_next;
    logic [SUMSQ_W-1:0]         rres_reg, rres_next;
    logic [SUMSQ_W-1:0]         rbit_reg, rbit_next;
    logic signed [SAMPLE_W-1:0] avg_x_reg, avg_x_next;
    logic signed [SAMPLE_W-1:0] avg_y_reg, avg_y_next;
    logic signed [SAMPLE_W-1:0] avg_z_reg, avg_z_next;
    logic [MAG_W-1:0]           mag_reg, mag_next;
    logic [FILL_LEVEL_W-1:0]    lvl_reg, lvl_next;

    logic [MEM_W-1:0]           rdata;
    logic signed [SAMPLE_W-1:0] avg [AXES];
    logic signed [SAMPLE_W-1:0] mul_op;
    logic signed [SUMSQ_W-1:0]  mul_res;
    logic [SUMSQ_W:0]           root_trial;

    amam_ram #(
        .WIDTH (MEM_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (slot_reg),
        .wdata ({accel_z, accel_y, accel_x}),
        .re    (cmd.rd_issue),
        .raddr (rd_addr_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg       <= '0;
            fill_reg       <= '0;
            rd_addr_reg    <= '0;
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            slot_reg       <= slot_next;
            fill_reg       <= fill_next;
            rd_addr_reg    <= rd_addr_next;
            rd_valid_reg   <= rd_valid_next;
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        neg_reg   <= neg_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        prod_reg  <= prod_next;
        sumsq_reg <= sumsq_next;
        rv_reg    <= rv_next;
        rres_reg  <= rres_next;
        rbit_reg  <= rbit_next;
        avg_x_reg <= avg_x_next;
        avg_y_reg <= avg_y_next;
        avg_z_reg <= avg_z_next;
        mag_reg   <= mag_next;
        lvl_reg   <= lvl_next;
    end

    // quotient magnitude fits 16 bits, sign restored here
    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            avg[k] = neg_reg[k] ? -$signed(dvd_reg[k][SAMPLE_W-1:0])
                                :  $signed(dvd_reg[k][SAMPLE_W-1:0]);
        end
    end

    always_comb
    begin
        unique case (cmd.sq_sel)
            AXIS_X:  mul_op = avg[0];
            AXIS_Y:  mul_op = avg[1];
            AXIS_Z:  mul_op = avg[2];
            default: mul_op = '0;
        endcase
        mul_res    = mul_op * mul_op;
        root_trial = {1'b0, rres_reg} + {1'b0, rbit_reg};
    end

    always_comb
    begin
        logic [RW-1:0] trial;
        logic          ge;
        logic [SW-1:0] mag_sum;

        trial           = '0;
        ge              = 1'b0;
        mag_sum         = '0;
        slot_next       = slot_reg;
        fill_next       = fill_reg;
        rd_addr_next    = rd_addr_reg;
        rd_valid_next   = cmd.rd_issue;
        prod_valid_next = cmd.sq_issue;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        prod_next       = prod_reg;
        sumsq_next      = sumsq_reg;
        rv_next         = rv_reg;
        rres_next       = rres_reg;
        rbit_next       = rbit_reg;
        avg_x_next      = avg_x_reg;
        avg_y_next      = avg_y_reg;
        avg_z_next      = avg_z_reg;
        mag_next        = mag_reg;
        lvl_next        = lvl_reg;
        out_valid_next  = out_valid_reg;

        if (cmd.load)
        begin
            slot_next    = (slot_reg == AW'(WINDOW - 1)) ? '0 : slot_reg + AW'(1);
            fill_next    = (fill_reg == FW'(WINDOW)) ? fill_reg : fill_reg + FW'(1);
            rd_addr_next = '0;
            for (int k = 0; k < AXES; k++)
            begin
                acc_next[k] = '0;
            end
        end

        if (cmd.rd_issue)
        begin
            rd_addr_next = rd_addr_reg + AW'(1);
        end

        if (rd_valid_reg)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                acc_next[k] = acc_reg[k]
                            + SW'($signed(rdata[k*SAMPLE_W +: SAMPLE_W]));
            end
        end

        if (cmd.div_init)
        begin
            sumsq_next = '0;
            for (int k = 0; k < AXES; k++)
            begin
                mag_sum     = acc_reg[k][SW-1] ? -acc_reg[k] : acc_reg[k];
                neg_next[k] = acc_reg[k][SW-1];
                dvd_next[k] = mag_sum[MW-1:0];
                rem_next[k] = '0;
            end
        end

        // restoring division, one quotient bit per axis per cycle
        if (cmd.div_step)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                trial       = {rem_reg[k], dvd_reg[k][MW-1]};
                ge          = (trial >= RW'(fill_reg));
                rem_next[k] = ge ? FW'(trial - RW'(fill_reg)) : FW'(trial);
                dvd_next[k] = {dvd_reg[k][MW-2:0], ge};
            end
        end

        if (cmd.sq_issue)
        begin
            prod_next = SUMSQ_W'(mul_res);
        end

        if (prod_valid_reg)
        begin
            sumsq_next = sumsq_reg + prod_reg;
        end

        if (cmd.root_init)
        begin
            rv_next   = sumsq_reg;
            rres_next = '0;
            rbit_next = ROOT_BIT0;
        end

        // digit-by-digit square root, one result bit per cycle
        if (cmd.root_step)
        begin
            if ({1'b0, rv_reg} >= root_trial)
            begin
                rv_next   = rv_reg - root_trial[SUMSQ_W-1:0];
                rres_next = (rres_reg >> 1) + rbit_reg;
            end
            else
            begin
                rres_next = rres_reg >> 1;
            end
            rbit_next = rbit_reg >> 2;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.out_load)
        begin
            avg_x_next     = avg[0];
            avg_y_next     = avg[1];
            avg_z_next     = avg[2];
            mag_next       = rres_reg[MAG_W-1:0];
            lvl_next       = FILL_LEVEL_W'(fill_reg);
            out_valid_next = 1'b1;
        end
    end

    assign sts.rd_last  = ((FW'(rd_addr_reg) + FW'(1)) == fill_reg);
    assign sts.out_busy = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign avg_x      = avg_x_reg;
    assign avg_y      = avg_y_reg;
    assign avg_z      = avg_z_reg;
    assign magnitude  = mag_reg;
    assign fill_level = lvl_reg;

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg <= FW'(WINDOW)) && (slot_reg <= AW'(WINDOW - 1)))
        else $error("fill count or write slot out of range");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && (fill_reg != FW'(WINDOW))) |=> (fill_reg == $past(fill_reg) + FW'(1)))
        else $error("fill count did not advance on a new sample");

    a_read_written: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |-> (FW'(rd_addr_reg) < fill_reg))
        else $error("ring read beyond filled entries");

    a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (rres_reg[SUMSQ_W-1:MAG_W] == '0))
        else $error("square root wider than magnitude field");

endmodule

// ===== src/accel_moving_average_magnitude.sv =====
// Throughput: one request at a time; the next is taken the cycle after the result is
//   registered. Set by the ring read sweep, the bit-serial dividers and the 16-step root.
// Reset: rst_n clears write slot, fill count, sequencer and valid flags; ring contents
//   are not cleared and are only read once written.
module accel_moving_average_magnitude import amam_pkg::*; #(
    parameter int WINDOW = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_W-1:0]     accel_x,
    input  logic signed [SAMPLE_W-1:0]     accel_y,
    input  logic signed [SAMPLE_W-1:0]     accel_z,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_W-1:0]     avg_x,
    output logic signed [SAMPLE_W-1:0]     avg_y,
    output logic signed [SAMPLE_W-1:0]     avg_z,
    output logic [MAG_W-1:0]               magnitude,
    output logic [FILL_LEVEL_W-1:0]        fill_level
);

    amam_cmd_t cmd;
    amam_sts_t sts;

    amam_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    amam_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .accel_x    (accel_x),
        .accel_y    (accel_y),
        .accel_z    (accel_z),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .avg_x      (avg_x),
        .avg_y      (avg_y),
        .avg_z      (avg_z),
        .magnitude  (magnitude),
        .fill_level (fill_level)
    );

endmodule
